/* rtl/core/htbd_pkg.sv */
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared types, field widths and codes of the Huffman table bit-stream
// decoder: request and result codes, sequencer states, table entry layout.
// ----------------------------------------------------------------------------
package htbd_pkg;

   // default sizes of the code table and of the longest code
   localparam int TABLE_ENTRIES_DEF = 129;
   localparam int MAX_CODE_BITS_DEF = 16;

   // fixed field widths
   localparam int INDEX_W = 8;
   localparam int LEN_W   = 5;
   localparam int BITS_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int LEFT_W  = $clog2(BYTE_W);
   localparam int SYM_W   = 7;
   localparam int KIND_W  = 2;
   localparam int REQ_W   = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_START = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_OUT,
      ST_NEXT
   } state_type;

   // one stored table entry
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [BITS_W-1:0] bits;
   } entry_type;

   // control from the sequencer to the match unit
   typedef struct packed {
      logic clear;
      logic advance;
   } match_ctl_type;

   // accumulated match status for the current stream bit
   typedef struct packed {
      logic hit;
      logic prefix;
   } match_res_type;

endpackage

/* rtl/core/htbd_table.sv */
// ----------------------------------------------------------------------------
// htbd_table
// Code table storage: one entry memory with registered read and a valid bit
// per entry, so that never-loaded entries read as unused (length zero).
// ----------------------------------------------------------------------------
module htbd_table #(
   parameter int TABLE_ENTRIES = htbd_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
   input  htbd_pkg::entry_type            wr_entry,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_idx,
   output logic [htbd_pkg::LEN_W-1:0]     rd_len,
   output logic [htbd_pkg::BITS_W-1:0]    rd_bits
);

   htbd_pkg::entry_type         entry_ram_ff [TABLE_ENTRIES];
   htbd_pkg::entry_type         rd_entry_ff;
   logic [TABLE_ENTRIES-1:0]    vld_ff;
   logic                        rd_vld_ff;

   // entry memory, written by loads, read during the table sweep
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ram_ff[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_ram_ff[rd_idx];
      end
   end

   // per-entry valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_idx];
         end
      end
   end

   // an entry never loaded reads as unused
   assign rd_len  = rd_vld_ff ? rd_entry_ff.len : '0;
   assign rd_bits = rd_entry_ff.bits;

endmodule

/* rtl/core/htbd_match.sv */
// ----------------------------------------------------------------------------
// htbd_match
// Shared compare unit: checks one table entry a cycle against the pending
// code bits and accumulates complete-code hits and longer-code prefixes.
// ----------------------------------------------------------------------------
module htbd_match #(
   parameter int TABLE_ENTRIES = htbd_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_CODE_BITS = htbd_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  htbd_pkg::match_ctl_type               ctl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]      ent_idx,
   input  logic [htbd_pkg::LEN_W-1:0]            ent_len,
   input  logic [htbd_pkg::BITS_W-1:0]           ent_bits,
   input  logic [MAX_CODE_BITS-1:0]              pend,
   input  logic [$clog2(MAX_CODE_BITS+1)-1:0]    cnt,
   output htbd_pkg::match_res_type               res,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      hit_idx
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(MAX_CODE_BITS + 1);
   localparam int CMP_W = (htbd_pkg::LEN_W > CNT_W) ? htbd_pkg::LEN_W : CNT_W;
   localparam int SW    = (htbd_pkg::BITS_W > MAX_CODE_BITS) ? htbd_pkg::BITS_W
                                                             : MAX_CODE_BITS;

   logic [CMP_W-1:0] len_e;
   logic [CMP_W-1:0] cnt_e;
   logic [CMP_W-1:0] shamt;
   logic [SW-1:0]    shifted;
   logic [SW-1:0]    mask;
   logic             live;
   logic             reach;
   logic             exact;
   logic             match;
   logic             hit_ff;
   logic             prefix_ff;
   logic [IDX_W-1:0] hit_idx_ff;

   // leading bits of the entry code against the pending bits
   always_comb begin
      len_e   = CMP_W'(ent_len);
      cnt_e   = CMP_W'(cnt);
      live    = (len_e != '0) && (len_e <= CMP_W'(MAX_CODE_BITS));
      reach   = (len_e >= cnt_e);
      exact   = (len_e == cnt_e);
      shamt   = len_e - cnt_e;
      shifted = SW'(ent_bits) >> shamt;
      for (int k = 0; k < SW; k++) begin
         mask[k] = (CMP_W'(k) < cnt_e);
      end
      match = live && reach && ((shifted & mask) == SW'(pend));
   end

   // hit and prefix flags for the bit in progress
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff    <= 1'b0;
         prefix_ff <= 1'b0;
      end else if (ctl.clear) begin
         hit_ff    <= 1'b0;
         prefix_ff <= 1'b0;
      end else if (ctl.advance && match) begin
         if (exact) begin
            hit_ff <= 1'b1;
         end else begin
            prefix_ff <= 1'b1;
         end
      end
   end

   // the sweep runs upward, so the highest matching index stays
   always_ff @(posedge clock) begin
      if (ctl.advance && match && exact) begin
         hit_idx_ff <= ent_idx;
      end
   end

   assign res.hit    = hit_ff;
   assign res.prefix = prefix_ff;
   assign hit_idx    = hit_idx_ff;

endmodule

/* rtl/core/huffman_table_bitstream_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_table_bitstream_decoder
// Huffman decoder against a loadable code table, with the bit sequencer.
// ----------------------------------------------------------------------------
// Loads and new-stream requests are handled in idle. A code byte is decoded
// one bit at a time: for each bit a single compare unit sweeps the whole
// code table memory, one entry per cycle. Results of a byte leave one behind
// the decoding so the last one can carry last_of_run. req_stall is high while
// the sequencer is not idle: from a byte transfer until it returns to idle
// after the byte's final result is taken.
// ----------------------------------------------------------------------------
module huffman_table_bitstream_decoder #(
   parameter int TABLE_ENTRIES = htbd_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_CODE_BITS = htbd_pkg::MAX_CODE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [htbd_pkg::REQ_W-1:0]     req_type,
   input  logic [htbd_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [htbd_pkg::LEN_W-1:0]     req_entry_length,
   input  logic [htbd_pkg::BITS_W-1:0]    req_entry_bits,
   input  logic [htbd_pkg::BYTE_W-1:0]    req_code_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [htbd_pkg::SYM_W-1:0]     rsp_out_symbol,
   output logic [htbd_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic                           rsp_last_of_run
);

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_CODE_BITS + 1);
   localparam int IDXP_W = htbd_pkg::INDEX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   htbd_pkg::state_type                 state_ff, state_in;
   logic [IDX_W-1:0]                    scan_ff, scan_in;
   logic                                adv_ff, adv_in;
   logic [IDX_W-1:0]                    adv_idx_ff, adv_idx_in;
   logic [htbd_pkg::BYTE_W-1:0]         byte_ff, byte_in;
   logic [htbd_pkg::LEFT_W-1:0]         left_ff, left_in;
   logic [MAX_CODE_BITS-1:0]            pend_ff, pend_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic                                halted_ff, halted_in;
   logic                                fin_ff, fin_in;
   logic                                held_vld_ff, held_vld_in;
   logic [htbd_pkg::KIND_W-1:0]         held_kind_ff, held_kind_in;
   logic [htbd_pkg::SYM_W-1:0]          held_sym_ff, held_sym_in;
   logic [htbd_pkg::KIND_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic [htbd_pkg::SYM_W-1:0]          rsp_sym_ff, rsp_sym_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                req_accept;
   logic                                idx_ok;
   logic                                tbl_wr_en;
   logic                                tbl_rd_en;
   htbd_pkg::entry_type                 tbl_wr_entry;
   logic [htbd_pkg::LEN_W-1:0]          tbl_rd_len;
   logic [htbd_pkg::BITS_W-1:0]         tbl_rd_bits;
   htbd_pkg::match_ctl_type             mctl;
   htbd_pkg::match_res_type             mres;
   logic [IDX_W-1:0]                    hit_idx;
   logic                                new_res;
   logic                                halting;
   logic [htbd_pkg::KIND_W-1:0]         new_kind;
   logic [htbd_pkg::SYM_W-1:0]          new_sym;

   // code table storage
   htbd_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_idx   (IDX_W'(req_entry_index)),
      .wr_entry (tbl_wr_entry),
      .rd_en    (tbl_rd_en),
      .rd_idx   (scan_ff),
      .rd_len   (tbl_rd_len),
      .rd_bits  (tbl_rd_bits)
   );

   // shared compare unit
   htbd_match #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_match (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mctl),
      .ent_idx  (adv_idx_ff),
      .ent_len  (tbl_rd_len),
      .ent_bits (tbl_rd_bits),
      .pend     (pend_ff),
      .cnt      (cnt_ff),
      .res      (mres),
      .hit_idx  (hit_idx)
   );

   // handshake and load data
   assign req_stall         = (state_ff != htbd_pkg::ST_IDLE);
   assign req_accept        = req_valid && !req_stall;
   assign idx_ok            = ({1'b0, req_entry_index} < IDXP_W'(TABLE_ENTRIES));
   assign tbl_wr_entry.len  = req_entry_length;
   assign tbl_wr_entry.bits = req_entry_bits;
   assign rsp_valid         = (state_ff == htbd_pkg::ST_OUT);
   assign rsp_out_symbol    = rsp_sym_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      adv_in       = 1'b0;
      adv_idx_in   = adv_idx_ff;
      byte_in      = byte_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      halted_in    = halted_ff;
      fin_in       = fin_ff;
      held_vld_in  = held_vld_ff;
      held_kind_in = held_kind_ff;
      held_sym_in  = held_sym_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_last_in  = rsp_last_ff;
      tbl_wr_en    = 1'b0;
      tbl_rd_en    = 1'b0;
      mctl.clear   = 1'b0;
      mctl.advance = adv_ff;
      new_res      = 1'b0;
      halting      = 1'b0;
      new_kind     = htbd_pkg::KIND_SYMBOL;
      new_sym      = '0;

      case (state_ff)
         htbd_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  htbd_pkg::REQ_LOAD: begin
                     tbl_wr_en = idx_ok;
                  end
                  htbd_pkg::REQ_START: begin
                     pend_in   = '0;
                     cnt_in    = '0;
                     halted_in = 1'b0;
                  end
                  htbd_pkg::REQ_BYTE: begin
                     if (!halted_ff) begin
                        pend_in    = MAX_CODE_BITS'({pend_ff, req_code_byte[htbd_pkg::BYTE_W-1]});
                        cnt_in     = CNT_W'(cnt_ff + 1'b1);
                        byte_in    = req_code_byte << 1;
                        left_in    = htbd_pkg::LEFT_W'(htbd_pkg::BYTE_W - 1);
                        mctl.clear = 1'b1;
                        scan_in    = '0;
                        state_in   = htbd_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // sweep the table, one entry read per cycle
         htbd_pkg::ST_SCAN: begin
            tbl_rd_en  = 1'b1;
            adv_in     = 1'b1;
            adv_idx_in = scan_ff;
            if (scan_ff == LAST_IDX) begin
               state_in = htbd_pkg::ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         // last entry leaves the read register
         htbd_pkg::ST_DRAIN: begin
            state_in = htbd_pkg::ST_DECIDE;
         end

         // resolve the bit: symbol, end, error or keep gathering
         htbd_pkg::ST_DECIDE: begin
            if (mres.hit) begin
               pend_in = '0;
               cnt_in  = '0;
               new_res = 1'b1;
               if (hit_idx == LAST_IDX) begin
                  new_kind  = htbd_pkg::KIND_END;
                  halting   = 1'b1;
               end else begin
                  new_kind = htbd_pkg::KIND_SYMBOL;
                  new_sym  = htbd_pkg::SYM_W'(hit_idx);
               end
            end else if (!mres.prefix) begin
               pend_in  = '0;
               cnt_in   = '0;
               new_res  = 1'b1;
               new_kind = htbd_pkg::KIND_ERROR;
               halting  = 1'b1;
            end
            if (halting) begin
               halted_in = 1'b1;
            end
            fin_in   = halting || (left_ff == '0);
            state_in = htbd_pkg::ST_NEXT;
            if (new_res) begin
               held_vld_in  = 1'b1;
               held_kind_in = new_kind;
               held_sym_in  = new_sym;
               if (held_vld_ff) begin
                  rsp_kind_in = held_kind_ff;
                  rsp_sym_in  = held_sym_ff;
                  rsp_last_in = 1'b0;
                  state_in    = htbd_pkg::ST_OUT;
               end
            end
         end

         // result waits for its transfer
         htbd_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = htbd_pkg::ST_NEXT;
            end
         end

         // flush the held result at byte end, or start the next bit
         htbd_pkg::ST_NEXT: begin
            if (fin_ff) begin
               if (held_vld_ff) begin
                  rsp_kind_in = held_kind_ff;
                  rsp_sym_in  = held_sym_ff;
                  rsp_last_in = 1'b1;
                  held_vld_in = 1'b0;
                  state_in    = htbd_pkg::ST_OUT;
               end else begin
                  state_in = htbd_pkg::ST_IDLE;
               end
            end else begin
               pend_in    = MAX_CODE_BITS'({pend_ff, byte_ff[htbd_pkg::BYTE_W-1]});
               cnt_in     = CNT_W'(cnt_ff + 1'b1);
               byte_in    = byte_ff << 1;
               left_in    = left_ff - 1'b1;
               mctl.clear = 1'b1;
               scan_in    = '0;
               state_in   = htbd_pkg::ST_SCAN;
            end
         end

         default: begin
            state_in = htbd_pkg::ST_IDLE;
         end
      endcase
   end

   // control and stream state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= htbd_pkg::ST_IDLE;
         scan_ff     <= '0;
         adv_ff      <= 1'b0;
         left_ff     <= '0;
         pend_ff     <= '0;
         cnt_ff      <= '0;
         halted_ff   <= 1'b0;
         fin_ff      <= 1'b0;
         held_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_ff     <= scan_in;
         adv_ff      <= adv_in;
         left_ff     <= left_in;
         pend_ff     <= pend_in;
         cnt_ff      <= cnt_in;
         halted_ff   <= halted_in;
         fin_ff      <= fin_in;
         held_vld_ff <= held_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      adv_idx_ff   <= adv_idx_in;
      byte_ff      <= byte_in;
      held_kind_ff <= held_kind_in;
      held_sym_ff  <= held_sym_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule
